// ===== sv/ssht_pkg.sv =====
// Shared constants and types for the segment/sphere hit test pipeline.
// No dependencies; every other file refers to this package by scoped names.
package ssht_pkg;

	// default coordinate width (signed Q12.12)
	localparam int COORD_BITS_DEF = 24;
	// radius width (unsigned Q11.12)
	localparam int RADIUS_BITS = 23;
	// master-side word width: hit bit padded to a byte
	localparam int OUT_W = 8;

	// decision flags that ride along with the wide products
	typedef struct packed {
		logic sphere_ok;  // sphere marked valid
		logic end_in;     // end point inside or on the sphere
		logic start_in;   // start point inside or on the sphere
		logic too_short;  // segment shorter than start-to-center distance
		logic behind;     // center lies behind the start point
		logic past_end;   // (center - end) . (end - start) < 0
	} ssht_flags_t;

endpackage

// ===== sv/segment_sphere_hit_test.sv =====
// Top level of the segment/sphere hit test: stream ports, valid/stall chain,
// final decision. Depends on ssht_pkg, ssht_diff, ssht_prod, ssht_sum, ssht_wmul.

// Takes one segment/sphere query per clock when the output is not held off,
// and returns one hit word per query, in order.
// The pipeline is seven register stages (differences, products, sums, compares,
// two stages of split wide multiply, decision); each stage moves on when it is
// empty or the stage after it moves, so gaps close up and a stalled output
// does not block input until every stage holds a word. All tests are exact
// integer compares on squared quantities; the distance-to-line test uses
// t^2 < (|c-s|^2 - r^2) * |e-s|^2 with t = (c-s).(e-s), computed on the
// 2*COORD_BITS+2 bit operands split in halves across the two multiply stages.
module segment_sphere_hit_test #(
	parameter int COORD_BITS = ssht_pkg::COORD_BITS_DEF,
	localparam int DATA_W = ((9 * COORD_BITS + ssht_pkg::RADIUS_BITS + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// center_x, center_y, center_z, sphere_radius, start_x, start_y, start_z,
	// end_x, end_y, end_z, zero fill
	input  logic [DATA_W-1:0]           s_tdata,
	// sphere_valid
	input  logic                        s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// hit, zero fill
	output logic [ssht_pkg::OUT_W-1:0]  m_tdata
);

	localparam int C   = COORD_BITS;
	localparam int RB  = ssht_pkg::RADIUS_BITS;
	localparam int D   = 2 * C + 2;
	localparam int OFS = 3 * C + RB;
	localparam int OFE = 6 * C + RB;

	logic signed [C-1:0]      cen [3];
	logic signed [C-1:0]      sp [3];
	logic signed [C-1:0]      ep [3];
	logic [RB-1:0]            rad;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	logic                     sv_s1, sv_s2;
	logic [RB-1:0]            rad_s1;
	logic signed [C:0]        v0_s1 [3];
	logic signed [C:0]        v1_s1 [3];
	logic signed [C:0]        v2_s1 [3];
	logic [2*RB-1:0]          r2_s2;
	logic signed [2*C+1:0]    p00_s2 [3];
	logic signed [2*C+1:0]    p11_s2 [3];
	logic signed [2*C+1:0]    p22_s2 [3];
	logic signed [2*C+1:0]    p12_s2 [3];
	logic signed [2*C+1:0]    p02_s2 [3];
	ssht_pkg::ssht_flags_t    flags_s4, flags_s5, flags_s6;
	logic [D-1:0]             a_s4, b_s4, d2_s4;
	logic [2*D-1:0]           sq_s6, pr_s6;
	logic                     far;
	logic                     hit_s7;

	// unpack the slave word
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cen[i] = s_tdata[i*C +: C];
			sp[i]  = s_tdata[OFS + i*C +: C];
			ep[i]  = s_tdata[OFE + i*C +: C];
		end
		rad = s_tdata[3*C +: RB];
	end

	// stall chain: a stage loads when it is empty or its successor loads
	assign en7      = !vld_s7 || m_tready;
	assign en6      = !vld_s6 || en7;
	assign en5      = !vld_s5 || en6;
	assign en4      = !vld_s4 || en5;
	assign en3      = !vld_s3 || en4;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign s_tready = en1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= s_tvalid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
			if (en7) vld_s7 <= vld_s6;
		end
	end

	ssht_diff #(.COORD_BITS(C)) u_diff (
		.clk           (clk),
		.en            (en1),
		.sphere_valid  (s_tuser),
		.cen           (cen),
		.sp            (sp),
		.ep            (ep),
		.sphere_radius (rad),
		.sv_s1         (sv_s1),
		.rad_s1        (rad_s1),
		.v0_s1         (v0_s1),
		.v1_s1         (v1_s1),
		.v2_s1         (v2_s1)
	);

	ssht_prod #(.COORD_BITS(C)) u_prod (
		.clk    (clk),
		.en     (en2),
		.sv_s1  (sv_s1),
		.rad_s1 (rad_s1),
		.v0_s1  (v0_s1),
		.v1_s1  (v1_s1),
		.v2_s1  (v2_s1),
		.sv_s2  (sv_s2),
		.r2_s2  (r2_s2),
		.p00_s2 (p00_s2),
		.p11_s2 (p11_s2),
		.p22_s2 (p22_s2),
		.p12_s2 (p12_s2),
		.p02_s2 (p02_s2)
	);

	ssht_sum #(.COORD_BITS(C)) u_sum (
		.clk      (clk),
		.en3      (en3),
		.en4      (en4),
		.sv_s2    (sv_s2),
		.r2_s2    (r2_s2),
		.p00_s2   (p00_s2),
		.p11_s2   (p11_s2),
		.p22_s2   (p22_s2),
		.p12_s2   (p12_s2),
		.p02_s2   (p02_s2),
		.flags_s4 (flags_s4),
		.a_s4     (a_s4),
		.b_s4     (b_s4),
		.d2_s4    (d2_s4)
	);

	// t^2
	ssht_wmul #(.W(D)) u_sq (
		.clk  (clk),
		.en1  (en5),
		.en2  (en6),
		.a    (a_s4),
		.b    (a_s4),
		.p_s2 (sq_s6)
	);

	// (d1 - r2) * d2
	ssht_wmul #(.W(D)) u_pr (
		.clk  (clk),
		.en1  (en5),
		.en2  (en6),
		.a    (b_s4),
		.b    (d2_s4),
		.p_s2 (pr_s6)
	);

	// flags ride alongside the wide multiply
	always_ff @(posedge clk) begin
		if (en5) flags_s5 <= flags_s4;
		if (en6) flags_s6 <= flags_s5;
	end

	// line passes farther from the center than the radius
	assign far = sq_s6 < pr_s6;

	// stage 7: ordered decision into the output register
	always_ff @(posedge clk) begin
		if (en7) begin
			hit_s7 <= flags_s6.sphere_ok &&
			          (flags_s6.end_in || flags_s6.start_in ||
			           (!flags_s6.too_short && !flags_s6.behind && !far &&
			            flags_s6.past_end));
		end
	end

	assign m_tvalid = vld_s7;
	assign m_tdata  = ssht_pkg::OUT_W'(hit_s7);

	// an empty output stage means the whole chain can take a word
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output stage empty");

	// words in flight change only by accepted inputs and delivered outputs
	a_word_count: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> $countones({vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7}) ==
			$past($countones({vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7}))
			+ int'($past(s_tvalid && s_tready)) - int'($past(m_tvalid && m_tready)))
		else $error("word lost or duplicated in pipeline");

endmodule

// ===== sv/ssht_diff.sv =====
// Stage 1: coordinate differences center-end, center-start, end-start.
// Depends on ssht_pkg.
module ssht_diff #(
	parameter int COORD_BITS = ssht_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic                                sphere_valid,
	input  logic signed [COORD_BITS-1:0]        cen [3],
	input  logic signed [COORD_BITS-1:0]        sp [3],
	input  logic signed [COORD_BITS-1:0]        ep [3],
	input  logic [ssht_pkg::RADIUS_BITS-1:0]    sphere_radius,
	output logic                                sv_s1,
	output logic [ssht_pkg::RADIUS_BITS-1:0]    rad_s1,
	output logic signed [COORD_BITS:0]          v0_s1 [3],
	output logic signed [COORD_BITS:0]          v1_s1 [3],
	output logic signed [COORD_BITS:0]          v2_s1 [3]
);

	localparam int VW = COORD_BITS + 1;

	// one subtract per component, sign extended by one bit
	always_ff @(posedge clk) begin
		if (en) begin
			sv_s1  <= sphere_valid;
			rad_s1 <= sphere_radius;
			for (int i = 0; i < 3; i++) begin
				v0_s1[i] <= VW'(cen[i]) - VW'(ep[i]);
				v1_s1[i] <= VW'(cen[i]) - VW'(sp[i]);
				v2_s1[i] <= VW'(ep[i]) - VW'(sp[i]);
			end
		end
	end

endmodule

// ===== sv/ssht_prod.sv =====
// Stage 2: component products for the squared lengths and dot products.
// Depends on ssht_pkg.
module ssht_prod #(
	parameter int COORD_BITS = ssht_pkg::COORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic                                  sv_s1,
	input  logic [ssht_pkg::RADIUS_BITS-1:0]      rad_s1,
	input  logic signed [COORD_BITS:0]            v0_s1 [3],
	input  logic signed [COORD_BITS:0]            v1_s1 [3],
	input  logic signed [COORD_BITS:0]            v2_s1 [3],
	output logic                                  sv_s2,
	output logic [2*ssht_pkg::RADIUS_BITS-1:0]    r2_s2,
	output logic signed [2*COORD_BITS+1:0]        p00_s2 [3],
	output logic signed [2*COORD_BITS+1:0]        p11_s2 [3],
	output logic signed [2*COORD_BITS+1:0]        p22_s2 [3],
	output logic signed [2*COORD_BITS+1:0]        p12_s2 [3],
	output logic signed [2*COORD_BITS+1:0]        p02_s2 [3]
);

	localparam int PW = 2 * COORD_BITS + 2;
	localparam int RW = 2 * ssht_pkg::RADIUS_BITS;

	// fifteen narrow signed multipliers plus the radius square
	always_ff @(posedge clk) begin
		if (en) begin
			sv_s2 <= sv_s1;
			r2_s2 <= RW'(rad_s1) * RW'(rad_s1);
			for (int i = 0; i < 3; i++) begin
				p00_s2[i] <= PW'(v0_s1[i]) * PW'(v0_s1[i]);
				p11_s2[i] <= PW'(v1_s1[i]) * PW'(v1_s1[i]);
				p22_s2[i] <= PW'(v2_s1[i]) * PW'(v2_s1[i]);
				p12_s2[i] <= PW'(v1_s1[i]) * PW'(v2_s1[i]);
				p02_s2[i] <= PW'(v0_s1[i]) * PW'(v2_s1[i]);
			end
		end
	end

endmodule

// ===== sv/ssht_sum.sv =====
// Stages 3 and 4: three-term sums, then the compares and the operands
// of the final wide test. Depends on ssht_pkg.
module ssht_sum #(
	parameter int COORD_BITS = ssht_pkg::COORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  en3,
	input  logic                                  en4,
	input  logic                                  sv_s2,
	input  logic [2*ssht_pkg::RADIUS_BITS-1:0]    r2_s2,
	input  logic signed [2*COORD_BITS+1:0]        p00_s2 [3],
	input  logic signed [2*COORD_BITS+1:0]        p11_s2 [3],
	input  logic signed [2*COORD_BITS+1:0]        p22_s2 [3],
	input  logic signed [2*COORD_BITS+1:0]        p12_s2 [3],
	input  logic signed [2*COORD_BITS+1:0]        p02_s2 [3],
	output ssht_pkg::ssht_flags_t                 flags_s4,
	output logic [2*COORD_BITS+1:0]               a_s4,
	output logic [2*COORD_BITS+1:0]               b_s4,
	output logic [2*COORD_BITS+1:0]               d2_s4
);

	// D: unsigned width of a squared length; S: signed width of any sum
	localparam int D  = 2 * COORD_BITS + 2;
	localparam int S  = 2 * COORD_BITS + 3;
	localparam int RW = 2 * ssht_pkg::RADIUS_BITS;
	localparam int M  = (D > RW) ? D : RW;

	logic                  sv_s3;
	logic [RW-1:0]         r2_s3;
	logic signed [S-1:0]   d0_s3, d1_s3, d2_s3, t_s3, w_s3;
	logic [M-1:0]          d1_less_r2;

	// stage 3: sums of three products
	always_ff @(posedge clk) begin
		if (en3) begin
			sv_s3 <= sv_s2;
			r2_s3 <= r2_s2;
			d0_s3 <= S'(p00_s2[0]) + S'(p00_s2[1]) + S'(p00_s2[2]);
			d1_s3 <= S'(p11_s2[0]) + S'(p11_s2[1]) + S'(p11_s2[2]);
			d2_s3 <= S'(p22_s2[0]) + S'(p22_s2[1]) + S'(p22_s2[2]);
			t_s3  <= S'(p12_s2[0]) + S'(p12_s2[1]) + S'(p12_s2[2]);
			w_s3  <= S'(p02_s2[0]) + S'(p02_s2[1]) + S'(p02_s2[2]);
		end
	end

	// only meaningful when the start point lies outside the sphere
	assign d1_less_r2 = M'(d1_s3[D-1:0]) - M'(r2_s3);

	// stage 4: ordered tests as flags; operands of t^2 < (d1 - r2) * d2
	always_ff @(posedge clk) begin
		if (en4) begin
			flags_s4.sphere_ok <= sv_s3;
			flags_s4.end_in    <= M'(d0_s3[D-1:0]) <= M'(r2_s3);
			flags_s4.start_in  <= M'(d1_s3[D-1:0]) <= M'(r2_s3);
			flags_s4.too_short <= d2_s3[D-1:0] < d1_s3[D-1:0];
			flags_s4.behind    <= t_s3[S-1];
			flags_s4.past_end  <= w_s3[S-1];
			a_s4               <= t_s3[D-1:0];
			b_s4               <= d1_less_r2[D-1:0];
			d2_s4              <= d2_s3[D-1:0];
		end
	end

endmodule

// ===== sv/ssht_wmul.sv =====
// Two-stage wide unsigned multiplier: four half-width partial products,
// then their sum. Depends on ssht_pkg for the default of W.
module ssht_wmul #(
	parameter int W = 2 * ssht_pkg::COORD_BITS_DEF + 2
) (
	input  logic             clk,
	input  logic             en1,
	input  logic             en2,
	input  logic [W-1:0]     a,
	input  logic [W-1:0]     b,
	output logic [2*W-1:0]   p_s2
);

	localparam int H = (W + 1) / 2;
	localparam int L = W - H;

	logic [2*H-1:0] ll_s1;
	logic [H+L-1:0] lh_s1, hl_s1;
	logic [2*L-1:0] hh_s1;
	logic [W:0]     mid;

	// stage 1: partial products, each half-width, 25 x 25 bits at the default W
	always_ff @(posedge clk) begin
		if (en1) begin
			ll_s1 <= (2*H)'(a[H-1:0]) * (2*H)'(b[H-1:0]);
			lh_s1 <= (H+L)'(a[H-1:0]) * (H+L)'(b[W-1:H]);
			hl_s1 <= (H+L)'(a[W-1:H]) * (H+L)'(b[H-1:0]);
			hh_s1 <= (2*L)'(a[W-1:H]) * (2*L)'(b[W-1:H]);
		end
	end

	assign mid = {1'b0, lh_s1} + {1'b0, hl_s1};

	// stage 2: recombine
	always_ff @(posedge clk) begin
		if (en2) begin
			p_s2 <= {hh_s1, ll_s1} + ({{(W-1){1'b0}}, mid} << H);
		end
	end

endmodule

// ===== test/tb_segment_sphere_hit_test.sv =====
// Self-checking bench for segment_sphere_hit_test: drives segment/sphere query words, predicts each
// hit bit with exact wide-integer math and checks the hit words in order.
// Depends on ssht_pkg and the segment_sphere_hit_test RTL.
module tb_segment_sphere_hit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_W = ssht_pkg::COORD_BITS_DEF;
	localparam int RADIUS_W = ssht_pkg::RADIUS_BITS;
	localparam int OUT_W = ssht_pkg::OUT_W;
	localparam int DATA_W = ((9 * COORD_W + RADIUS_W + 7) / 8) * 8;
	localparam int RANDOM_ITEMS = 1150;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int C_MIN = -(1 << (COORD_W - 1));
	localparam int C_MAX = (1 << (COORD_W - 1)) - 1;
	localparam int R_MAX = (1 << RADIUS_W) - 1;

	// one query as it travels on the slave side
	typedef struct {
		bit                        sphere_valid;
		logic [2:0][COORD_W-1:0]   center;
		logic [RADIUS_W-1:0]       radius;
		logic [2:0][COORD_W-1:0]   start_pt;
		logic [2:0][COORD_W-1:0]   end_pt;
	} query_t;

	// wide enough for the squared cross product times anything used here
	typedef logic signed [159:0] wide_t;

	typedef enum {SHAPE_NOISE, SHAPE_NEAR, SHAPE_THROUGH, SHAPE_POINT} shape_t;
	typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_PERIODIC, READY_STARVED} stall_t;

	// holds the hit bits still owed by the block, oldest first
	class hit_scoreboard;
		bit pending_hits[$];
		int unsigned mismatches;

		function wide_t dot3(wide_t a[3], wide_t b[3]);
			return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
		endfunction

		// exact hit decision; every length compare is on squares
		function bit predict_hit(query_t q);
			wide_t to_end[3], to_start[3], span[3];
			wide_t c_v, s_v, e_v, r_sq, cross_sq, term, start_sq, span_sq;
			int j, k;
			if (!q.sphere_valid)
				return 1'b0;
			for (int i = 0; i < 3; i++) begin
				c_v = $signed(q.center[i]);
				s_v = $signed(q.start_pt[i]);
				e_v = $signed(q.end_pt[i]);
				to_end[i] = c_v - e_v;
				to_start[i] = c_v - s_v;
				span[i] = e_v - s_v;
			end
			term = q.radius;
			r_sq = term * term;
			if (dot3(to_end, to_end) <= r_sq)
				return 1'b1;
			start_sq = dot3(to_start, to_start);
			if (start_sq <= r_sq)
				return 1'b1;
			span_sq = dot3(span, span);
			if (span_sq < start_sq)
				return 1'b0;
			if (dot3(to_start, span) < 0)
				return 1'b0;
			// squared distance to the line, scaled by the squared span length
			cross_sq = 0;
			for (int i = 0; i < 3; i++) begin
				j = (i + 1) % 3;
				k = (i + 2) % 3;
				term = to_start[j] * span[k] - to_start[k] * span[j];
				cross_sq = cross_sq + term * term;
			end
			if (r_sq * span_sq < cross_sq)
				return 1'b0;
			return dot3(to_end, span) < 0;
		endfunction

		function void note_query(query_t q);
			pending_hits = {pending_hits, predict_hit(q)};
		endfunction

		function void check_word(logic [OUT_W-1:0] word);
			bit want;
			if (pending_hits.size() == 0) begin
				$error("hit word 0x%0h arrived with no query waiting", word);
				mismatches++;
				return;
			end
			want = pending_hits.pop_front();
			if (word[0] !== want) begin
				$error("field hit: expected %0b, actual %0b", want, word[0]);
				mismatches++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata = '0;
	logic              s_tuser = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	hit_scoreboard sb = new();
	stall_t stall_mode = READY_ALWAYS;
	logic [15:0] stall_phase = '0;
	int unsigned quiet_cycles = 0;

	segment_sphere_hit_test dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver backpressure: mode is redrawn whenever the low six bits of stall_phase are zero
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1'b1;
		if (stall_phase[5:0] == 6'd0)
			stall_mode <= stall_t'($urandom_range(0, 3));
		case (stall_mode)
			READY_ALWAYS: begin
				m_tready <= 1'b1;
			end
			READY_COIN: begin
				m_tready <= ($urandom_range(0, 1) == 1);
			end
			READY_PERIODIC: begin
				m_tready <= (stall_phase[2:0] < 3'd5);
			end
			default: begin
				m_tready <= ($urandom_range(0, 7) == 0);
			end
		endcase
	end

	// check every hit word taken from the block
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata);
	end

	// watchdog on cycles where no word moves on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_segment_sphere_hit_test failed");
			$finish;
		end
	end

	function automatic query_t make_query(bit valid, int cx, int cy, int cz, int rad,
			int sx, int sy, int sz, int ex, int ey, int ez);
		query_t q;
		q.sphere_valid = valid;
		q.center[0] = COORD_W'(cx);
		q.center[1] = COORD_W'(cy);
		q.center[2] = COORD_W'(cz);
		q.radius = RADIUS_W'(rad);
		q.start_pt[0] = COORD_W'(sx);
		q.start_pt[1] = COORD_W'(sy);
		q.start_pt[2] = COORD_W'(sz);
		q.end_pt[0] = COORD_W'(ex);
		q.end_pt[1] = COORD_W'(ey);
		q.end_pt[2] = COORD_W'(ez);
		return q;
	endfunction

	function automatic int jitter(int mag);
		return int'($urandom_range(0, 2 * mag)) - mag;
	endfunction

	// mostly well-formed geometry around a sphere, some pure noise
	function automatic query_t random_query();
		query_t q;
		shape_t shape;
		int mag, fine, c, d;
		shape = shape_t'($urandom_range(0, 9) < 2 ? SHAPE_NOISE : $urandom_range(1, 3));
		mag = 1 << $urandom_range(2, 20);
		fine = (mag >> $urandom_range(0, 6)) + 1;
		q.sphere_valid = ($urandom_range(0, 9) != 0);
		q.radius = ($urandom_range(0, 7) == 0) ? '0 : RADIUS_W'($urandom_range(0, 2 * mag));
		for (int i = 0; i < 3; i++) begin
			c = int'($urandom_range(0, 1 << 23)) - (1 << 22);
			q.center[i] = COORD_W'(c);
			case (shape)
				SHAPE_NOISE: begin
					q.center[i] = COORD_W'($urandom);
					q.start_pt[i] = COORD_W'($urandom);
					q.end_pt[i] = COORD_W'($urandom);
				end
				SHAPE_NEAR: begin
					q.start_pt[i] = COORD_W'(c + jitter(mag));
					q.end_pt[i] = COORD_W'(c + jitter(mag));
				end
				SHAPE_THROUGH: begin
					// segment straddles the center, nudged off axis
					d = jitter(mag);
					q.start_pt[i] = COORD_W'(c - d + jitter(fine));
					q.end_pt[i] = COORD_W'(c + d + jitter(fine));
				end
				default: begin
					q.start_pt[i] = COORD_W'(c + jitter(mag));
					q.end_pt[i] = q.start_pt[i];
				end
			endcase
		end
		if (shape == SHAPE_NOISE) begin
			q.sphere_valid = $urandom_range(0, 1);
			q.radius = RADIUS_W'($urandom);
		end
		return q;
	endfunction

	// present one query word and hold it until the block takes it
	task automatic drive_query(input query_t q);
		s_tvalid <= 1'b1;
		s_tuser <= q.sphere_valid;
		s_tdata <= DATA_W'({q.end_pt, q.start_pt, q.radius, q.center});
		do @(posedge clk); while (!s_tready);
		sb.note_query(q);
	endtask

	initial begin
		int unsigned burst_left;
		int unsigned gap;

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// boundary and ordering cases
		drive_query(make_query(0, 0, 0, 0, 5, 100, 0, 0, 0, 0, 0));
		drive_query(make_query(1, 7, -3, 2, 0, 100, 0, 0, 7, -3, 2));
		drive_query(make_query(1, 7, -3, 2, 0, 7, -3, 2, 100, 0, 0));
		drive_query(make_query(1, 0, 0, 0, 5, 50, 50, 50, 50, 50, 50));
		drive_query(make_query(1, 1, 1, 1, 5, 2, 2, 2, 2, 2, 2));
		drive_query(make_query(1, 0, 0, 0, 5, 100, 0, 0, 3, 4, 0));
		drive_query(make_query(1, 0, 0, 0, 5, 3, -4, 0, 100, 0, 0));
		drive_query(make_query(1, 100, 0, 0, 5, 0, 0, 0, 1, 0, 0));
		drive_query(make_query(1, 10, 0, 0, 1, 0, 0, 0, -100, 0, 0));
		drive_query(make_query(1, 0, 0, 0, 10, -100, 0, 0, 100, 0, 0));
		drive_query(make_query(1, 0, 50, 0, 10, -100, 0, 0, 100, 0, 0));
		// tangent line: distance equals radius
		drive_query(make_query(1, 0, 10, 0, 10, -100, 0, 0, 100, 0, 0));
		// span length equals start-to-center distance
		drive_query(make_query(1, 3, 4, 0, 4, 0, 0, 0, 5, 0, 0));
		// full-scale coordinates and radius
		drive_query(make_query(1, C_MIN, C_MIN, C_MIN, R_MAX,
			C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN));
		drive_query(make_query(1, C_MAX, C_MAX, C_MAX, 0,
			C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN));
		drive_query(make_query(1, C_MAX, C_MIN, 0, R_MAX, C_MIN, C_MAX, 0, C_MAX, C_MIN, 1));
		drive_query(make_query(0, -1, -1, -1, R_MAX, -1, -1, -1, -1, -1, -1));
		drive_query(make_query(1, 0, 0, 0, R_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
		drive_query(make_query(1, C_MIN, 0, 0, 0, C_MAX, 0, 0, C_MIN, 0, 0));

		// random part: bursts with gaps, a full drain now and then
		burst_left = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 300 == 150) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (sb.pending_hits.size() != 0);
			end
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 12);
			end
			burst_left--;
			drive_query(random_query());
		end
		s_tvalid <= 1'b0;

		// wait for the last hit words, then let the pipe settle
		while (sb.pending_hits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("tb_segment_sphere_hit_test passed");
		else
			$display("tb_segment_sphere_hit_test failed");
		$finish;
	end
endmodule
